@@ sv/dmc_pkg.sv @@
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared sizes, codes and step tables of the depth-first maze carver.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int STACK_DEPTH = 1024;

  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int CELL_W    = ROW_W + COL_W;
  localparam int MAP_DEPTH = 1 << CELL_W;
  localparam int STK_AW    = $clog2(STACK_DEPTH);
  localparam int SP_W      = $clog2(STACK_DEPTH + 1);
  localparam int NB_W      = 10;

  localparam int GRID_W  = 7;
  localparam int START_W = 6;
  localparam int CRD_W   = 6;
  localparam int DEPTH_W = 11;
  localparam int PICK_W  = 8;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 7;
  localparam int OUT_DW  = 48;

  localparam logic signed [NB_W-1:0] STEP_DR [4] = '{-10'sd2, 10'sd2, 10'sd0, 10'sd0};
  localparam logic signed [NB_W-1:0] STEP_DC [4] = '{10'sd0, 10'sd0, -10'sd2, 10'sd2};

  typedef enum logic [1:0] {
    CMD_STEP  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    STS_CARVED   = 3'd0,
    STS_BACK     = 3'd1,
    STS_IDLE     = 3'd2,
    STS_STARTED  = 3'd3,
    STS_STOPPED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_ROWS      = 2'd0,
    CFG_COLS      = 2'd1,
    CFG_START_ROW = 2'd2,
    CFG_START_COL = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    FS_CLEAR,
    FS_IDLE,
    FS_TOP,
    FS_NB,
    FS_LAST,
    FS_PICK,
    FS_CARVE,
    FS_SEED,
    FS_DONE
  } fsm_e;

endpackage

@@ sv/dmc_ram.sv @@
// ----------------------------------------------------------------------------
// dmc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dmc_ram #(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/dfs_maze_carver.sv @@
// ----------------------------------------------------------------------------
// dfs_maze_carver
// Randomised depth-first maze carver over a cell map memory and a stack memory.
// ----------------------------------------------------------------------------
// Step: a carve passes TOP, NB, LAST, PICK, CARVE and DONE, a backtrack the same
//   without CARVE; NB makes four serial neighbour reads of the single map read port.
// Stop, ignored command, step while idle: straight to DONE.
// Start: a clearing pass over all MAP_DEPTH map entries, one map entry cleared per cycle, then SEED and DONE.
// Reset: a clearing pass over all MAP_DEPTH map entries; no transaction is accepted
//   until it ends, configuration writes are taken throughout.
module dfs_maze_carver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dmc_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [dmc_pkg::CFG_DW-1:0]  cfg_data_i,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [dmc_pkg::PICK_W-1:0]  s_axis_tdata,   // random_pick
  input  logic [1:0]                  s_axis_tuser,   // cmd
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // cur_row, cur_col, wall_row, wall_col, new_row, new_col, stack_depth, pad
  output logic [dmc_pkg::OUT_DW-1:0]  m_axis_tdata,
  output logic [2:0]                  m_axis_tuser    // status
);

  import dmc_pkg::*;

  fsm_e                      state_q, state_d;
  logic [GRID_W-1:0]         grid_rows_q, grid_cols_q;
  logic [START_W-1:0]        start_row_q, start_col_q;
  logic [SP_W-1:0]           sp_q;
  logic                      gen_q;
  logic [CELL_W-1:0]         clr_q;
  logic                      seed_q;
  logic [1:0]                nb_q;
  logic [1:0]                pidx_q;
  logic                      pin_q;
  logic [3:0]                cand_q;
  logic [PICK_W-1:0]         pick_q;
  logic [ROW_W-1:0]          r_q, nr_q;
  logic [COL_W-1:0]          c_q, nc_q;
  logic [2:0]                res_sts_q;
  logic [CRD_W-1:0]          res_cr_q, res_cc_q, res_wr_q, res_wc_q, res_nr_q, res_nc_q;
  logic                      out_valid_q;
  logic [OUT_DW-1:0]         out_data_q;
  logic [2:0]                out_user_q;

  logic                      map_we, map_wdata, map_rdata;
  logic [CELL_W-1:0]         map_waddr, map_raddr;
  logic                      stk_we;
  logic [STK_AW-1:0]         stk_waddr, stk_raddr;
  logic [CELL_W-1:0]         stk_wdata, stk_rdata;

  logic                      in_acc, out_free, step_go, start_in;
  logic [NB_W-1:0]           rows_eff, cols_eff;
  logic signed [NB_W-1:0]    sr, sc, nb_r, nb_c, ch_r, ch_c, ch_wr, ch_wc;
  logic                      nb_in;
  logic [2:0]                cnt;
  logic [10:0]               prod;
  logic [1:0]                sel, dir, k;
  logic                      found;

  dmc_ram #(.Width(1), .Depth(MAP_DEPTH)) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  dmc_ram #(.Width(CELL_W), .Depth(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == FS_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step_go       = gen_q && (sp_q != '0);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  assign rows_eff = (NB_W'(grid_rows_q) > NB_W'(MAX_ROWS)) ? NB_W'(MAX_ROWS)
                                                           : NB_W'(grid_rows_q);
  assign cols_eff = (NB_W'(grid_cols_q) > NB_W'(MAX_COLS)) ? NB_W'(MAX_COLS)
                                                           : NB_W'(grid_cols_q);
  assign start_in = (NB_W'(start_row_q) < rows_eff) && (NB_W'(start_col_q) < cols_eff);

  // neighbour under inspection
  assign sr    = signed'(NB_W'(r_q));
  assign sc    = signed'(NB_W'(c_q));
  assign nb_r  = sr + STEP_DR[nb_q];
  assign nb_c  = sc + STEP_DC[nb_q];
  assign nb_in = !nb_r[NB_W-1] && !nb_c[NB_W-1] && (nb_r < rows_eff) && (nb_c < cols_eff);

  // candidate choice
  always_comb begin
    cnt   = 3'($countones(cand_q));
    prod  = 11'(pick_q) * 11'(cnt);
    sel   = prod[9:8];
    dir   = 2'd0;
    k     = 2'd0;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (cand_q[i]) begin
        if (!found && k == sel) begin
          dir   = 2'(i);
          found = 1'b1;
        end
        k = k + 2'd1;
      end
    end
  end

  assign ch_r  = sr + STEP_DR[dir];
  assign ch_c  = sc + STEP_DC[dir];
  assign ch_wr = sr + (STEP_DR[dir] >>> 1);
  assign ch_wc = sc + (STEP_DC[dir] >>> 1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FS_CLEAR: begin
        if (clr_q == '1) begin
          state_d = seed_q ? FS_SEED : FS_IDLE;
        end
      end
      FS_IDLE: begin
        if (in_acc) begin
          case (s_axis_tuser)
            CMD_START: state_d = FS_CLEAR;
            CMD_STEP:  state_d = step_go ? FS_TOP : FS_DONE;
            default:   state_d = FS_DONE;
          endcase
        end
      end
      FS_TOP:   state_d = FS_NB;
      FS_NB:    state_d = (nb_q == 2'd3) ? FS_LAST : FS_NB;
      FS_LAST:  state_d = FS_PICK;
      FS_PICK:  state_d = (cnt == '0) ? FS_DONE : FS_CARVE;
      FS_CARVE: state_d = FS_DONE;
      FS_SEED:  state_d = FS_DONE;
      FS_DONE:  state_d = out_free ? FS_IDLE : FS_DONE;
      default:  state_d = FS_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    map_we    = 1'b0;
    map_waddr = clr_q;
    map_wdata = 1'b0;
    map_raddr = {nb_r[ROW_W-1:0], nb_c[COL_W-1:0]};
    stk_we    = 1'b0;
    stk_waddr = sp_q[STK_AW-1:0];
    stk_wdata = {ch_r[ROW_W-1:0], ch_c[COL_W-1:0]};
    stk_raddr = STK_AW'(sp_q - SP_W'(1));
    case (state_q)
      FS_CLEAR: begin
        map_we = 1'b1;
      end
      FS_PICK: begin
        if (cnt != '0) begin
          map_we    = 1'b1;
          map_waddr = {ch_wr[ROW_W-1:0], ch_wc[COL_W-1:0]};
          map_wdata = 1'b1;
          stk_we    = (sp_q < SP_W'(STACK_DEPTH));
        end
      end
      FS_CARVE: begin
        map_we    = 1'b1;
        map_waddr = {nr_q, nc_q};
        map_wdata = 1'b1;
      end
      FS_SEED: begin
        map_we    = start_in;
        map_waddr = {ROW_W'(start_row_q), COL_W'(start_col_q)};
        map_wdata = 1'b1;
        stk_we    = start_in;
        stk_waddr = '0;
        stk_wdata = {ROW_W'(start_row_q), COL_W'(start_col_q)};
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FS_CLEAR;
      grid_rows_q <= GRID_W'(63);
      grid_cols_q <= GRID_W'(63);
      start_row_q <= START_W'(1);
      start_col_q <= START_W'(1);
      sp_q        <= '0;
      gen_q       <= 1'b0;
      clr_q       <= '0;
      seed_q      <= 1'b0;
      nb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          CFG_ROWS:      grid_rows_q <= cfg_data_i;
          CFG_COLS:      grid_cols_q <= cfg_data_i;
          CFG_START_ROW: start_row_q <= cfg_data_i[START_W-1:0];
          CFG_START_COL: start_col_q <= cfg_data_i[START_W-1:0];
          default: ;
        endcase
      end
      if (state_q == FS_CLEAR) begin
        clr_q <= clr_q + CELL_W'(1);
      end
      if (state_q == FS_NB) begin
        nb_q <= nb_q + 2'd1;
      end
      if (in_acc) begin
        nb_q <= '0;
        case (s_axis_tuser)
          CMD_START: begin
            sp_q   <= '0;
            gen_q  <= 1'b0;
            clr_q  <= '0;
            seed_q <= 1'b1;
          end
          CMD_STOP: begin
            sp_q  <= '0;
            gen_q <= 1'b0;
          end
          CMD_STEP: begin
            if (!step_go) begin
              gen_q <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (state_q == FS_PICK) begin
        if (cnt == '0) begin
          sp_q <= sp_q - SP_W'(1);
        end else if (sp_q < SP_W'(STACK_DEPTH)) begin
          sp_q <= sp_q + SP_W'(1);
        end
      end
      if (state_q == FS_SEED && start_in) begin
        sp_q  <= SP_W'(1);
        gen_q <= 1'b1;
      end
      if (state_q == FS_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pick_q    <= s_axis_tdata;
      cand_q    <= '0;
      res_sts_q <= (s_axis_tuser == CMD_STOP) ? STS_STOPPED : STS_IDLE;
      res_cr_q  <= '0;
      res_cc_q  <= '0;
      res_wr_q  <= '0;
      res_wc_q  <= '0;
      res_nr_q  <= '0;
      res_nc_q  <= '0;
    end
    if (state_q == FS_TOP) begin
      r_q <= stk_rdata[CELL_W-1:COL_W];
      c_q <= stk_rdata[COL_W-1:0];
    end
    if (state_q == FS_NB) begin
      pidx_q <= nb_q;
      pin_q  <= nb_in;
    end
    if ((state_q == FS_NB && nb_q != 2'd0) || state_q == FS_LAST) begin
      cand_q[pidx_q] <= pin_q & ~map_rdata;
    end
    if (state_q == FS_PICK) begin
      nr_q     <= ch_r[ROW_W-1:0];
      nc_q     <= ch_c[COL_W-1:0];
      res_cr_q <= CRD_W'(r_q);
      res_cc_q <= CRD_W'(c_q);
      if (cnt == '0) begin
        res_sts_q <= STS_BACK;
      end else begin
        res_sts_q <= STS_CARVED;
        res_wr_q  <= ch_wr[CRD_W-1:0];
        res_wc_q  <= ch_wc[CRD_W-1:0];
        res_nr_q  <= ch_r[CRD_W-1:0];
        res_nc_q  <= ch_c[CRD_W-1:0];
      end
    end
    if (state_q == FS_SEED) begin
      res_sts_q <= STS_STARTED;
      res_cr_q  <= CRD_W'(start_row_q);
      res_cc_q  <= CRD_W'(start_col_q);
      res_nr_q  <= CRD_W'(start_row_q);
      res_nc_q  <= CRD_W'(start_col_q);
    end
    if (state_q == FS_DONE && out_free) begin
      out_user_q <= res_sts_q;
      out_data_q <= {1'b0, DEPTH_W'(sp_q), res_nc_q, res_nr_q,
                     res_wc_q, res_wr_q, res_cc_q, res_cr_q};
    end
  end

endmodule

@@ test/tb_dfs_maze_carver.sv @@
// ----------------------------------------------------------------------------
// tb_dfs_maze_carver
// Self-checking bench for the depth-first maze carver. Command transactions
// are fed from a backlog queue; each accepted command updates a local copy of
// the wall map and cell stack, and the resulting move is queued for comparison
// against the result stream. It covers directed corner cases, then random
// phases over several grid settings and handshake pressure modes.
// ----------------------------------------------------------------------------
module tb_dfs_maze_carver;
  import dmc_pkg::*;

  localparam logic [1:0] CMD_RSVD  = 2'd3;
  localparam int STALL_LIMIT       = 20000;
  localparam int HOLD_CYCLES       = 400;
  localparam int PHASE_ITEMS       = 156;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] pick;
  } maze_cmd_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  cur_row;
    logic [5:0]  cur_col;
    logic [5:0]  wall_row;
    logic [5:0]  wall_col;
    logic [5:0]  new_row;
    logic [5:0]  new_col;
    logic [10:0] depth;
  } maze_move_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [CFG_DW-1:0] cfg_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [PICK_W-1:0] s_axis_tdata = '0;
  logic [1:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_DW-1:0] m_axis_tdata;
  logic [2:0]        m_axis_tuser;

  dfs_maze_carver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // local copy of the carver state
  bit  wall_map [MAP_DEPTH];
  int  cell_stack [STACK_DEPTH];
  int  stack_ptr = 0;
  bit  carving = 1'b0;
  int  grid_rows_q = 63;
  int  grid_cols_q = 63;
  int  start_row_q = 1;
  int  start_col_q = 1;

  maze_cmd_t  cmd_backlog [$];
  maze_move_t maze_moves_q [$];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int mismatches = 0;
  int cmds_sent = 0;
  int moves_seen = 0;
  int starts_seen = 0;
  int carves_seen = 0;
  int backs_seen = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;

  initial begin
    foreach (wall_map[i]) wall_map[i] = 1'b1;
  end

  // up, down, left, right
  function automatic int row_step(input int d);
    return (d == 0) ? -2 : (d == 1) ? 2 : 0;
  endfunction

  function automatic int col_step(input int d);
    return (d == 2) ? -2 : (d == 3) ? 2 : 0;
  endfunction

  function automatic bit in_grid(input int r, input int c);
    int rows_lim;
    int cols_lim;
    rows_lim = (grid_rows_q > MAX_ROWS) ? MAX_ROWS : grid_rows_q;
    cols_lim = (grid_cols_q > MAX_COLS) ? MAX_COLS : grid_cols_q;
    return r >= 0 && c >= 0 && r < rows_lim && c < cols_lim;
  endfunction

  function automatic maze_move_t maze_next_move(input logic [1:0] cmd, input logic [7:0] pick);
    maze_move_t mv;
    int r, c, nr, nc, wr, wc, cnt, d, cell_idx;
    int cand [4];
    mv = '0;
    mv.status = STS_IDLE;
    if (cmd == CMD_START) begin
      foreach (wall_map[i]) wall_map[i] = 1'b1;
      stack_ptr = 0;
      carving = 1'b0;
      if (in_grid(start_row_q, start_col_q)) begin
        cell_idx = start_row_q * MAX_COLS + start_col_q;
        wall_map[cell_idx] = 1'b0;
        cell_stack[0] = cell_idx;
        stack_ptr = 1;
        carving = 1'b1;
      end
      mv.status  = STS_STARTED;
      mv.cur_row = 6'(start_row_q);
      mv.cur_col = 6'(start_col_q);
      mv.new_row = 6'(start_row_q);
      mv.new_col = 6'(start_col_q);
    end else if (cmd == CMD_STOP) begin
      carving = 1'b0;
      stack_ptr = 0;
      mv.status = STS_STOPPED;
    end else if (cmd == CMD_STEP) begin
      if (!carving || stack_ptr == 0) begin
        carving = 1'b0;
      end else begin
        r = cell_stack[stack_ptr - 1] / MAX_COLS;
        c = cell_stack[stack_ptr - 1] % MAX_COLS;
        cnt = 0;
        for (d = 0; d < 4; d++) begin
          nr = r + row_step(d);
          nc = c + col_step(d);
          if (in_grid(nr, nc) && wall_map[nr * MAX_COLS + nc]) begin
            cand[cnt] = d;
            cnt++;
          end
        end
        mv.cur_row = 6'(r);
        mv.cur_col = 6'(c);
        if (cnt > 0) begin
          d  = cand[(int'(pick) * cnt) >> 8];
          nr = r + row_step(d);
          nc = c + col_step(d);
          wr = r + row_step(d) / 2;
          wc = c + col_step(d) / 2;
          wall_map[wr * MAX_COLS + wc] = 1'b0;
          wall_map[nr * MAX_COLS + nc] = 1'b0;
          // full stack: cells opened, push dropped
          if (stack_ptr < STACK_DEPTH) begin
            cell_stack[stack_ptr] = nr * MAX_COLS + nc;
            stack_ptr++;
          end
          mv.status   = STS_CARVED;
          mv.wall_row = 6'(wr);
          mv.wall_col = 6'(wc);
          mv.new_row  = 6'(nr);
          mv.new_col  = 6'(nc);
        end else begin
          stack_ptr--;
          mv.status = STS_BACK;
        end
      end
    end
    mv.depth = 11'(stack_ptr);
    return mv;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // command driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        maze_moves_q = {maze_moves_q, maze_next_move(s_axis_tuser, s_axis_tdata)};
        void'(cmd_backlog.pop_front());
        cmds_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_backlog.size() > 0 && int'($urandom_range(99)) >= sender_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cmd_backlog[0].cmd;
          s_axis_tdata  <= cmd_backlog[0].pick;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    maze_move_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        moves_seen++;
        if (maze_moves_q.size() == 0) begin
          $error("result transaction with no expectation pending");
          mismatches++;
        end else begin
          want = maze_moves_q.pop_front();
          case (want.status)
            STS_STARTED: starts_seen++;
            STS_CARVED:  carves_seen++;
            STS_BACK:    backs_seen++;
            default: ;
          endcase
          check_field("status",      int'(want.status),   int'(m_axis_tuser));
          check_field("cur_row",     int'(want.cur_row),  int'(m_axis_tdata[5:0]));
          check_field("cur_col",     int'(want.cur_col),  int'(m_axis_tdata[11:6]));
          check_field("wall_row",    int'(want.wall_row), int'(m_axis_tdata[17:12]));
          check_field("wall_col",    int'(want.wall_col), int'(m_axis_tdata[23:18]));
          check_field("new_row",     int'(want.new_row),  int'(m_axis_tdata[29:24]));
          check_field("new_col",     int'(want.new_col),  int'(m_axis_tdata[35:30]));
          check_field("stack_depth", int'(want.depth),    int'(m_axis_tdata[46:36]));
        end
      end
      if (hold_requests != holds_served) begin
        hold_left = HOLD_CYCLES;
        holds_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= int'($urandom_range(99)) >= receiver_stall_pct;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_cmd(input logic [1:0] cmd, input int pick);
    maze_cmd_t item;
    item.cmd  = cmd;
    item.pick = 8'(pick);
    cmd_backlog = {cmd_backlog, item};
  endtask

  task automatic drain_wait();
    while (cmd_backlog.size() != 0 || maze_moves_q.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_e idx, input int value);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= 7'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ROWS:      grid_rows_q = value;
      CFG_COLS:      grid_cols_q = value;
      CFG_START_ROW: start_row_q = value;
      CFG_START_COL: start_col_q = value;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic program_grid(input int rows, input int cols, input int srow, input int scol);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_START_ROW, srow);
    write_reg(CFG_START_COL, scol);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int ph;
    int n;
    int r;
    logic [1:0] cmd;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: idle step, reserved command, stop while idle, start, steps, stop, step after stop
    queue_cmd(CMD_STEP, 0);
    queue_cmd(CMD_RSVD, 255);
    queue_cmd(CMD_STOP, 0);
    queue_cmd(CMD_START, 8'h55);
    queue_cmd(CMD_STEP, 0);
    queue_cmd(CMD_STEP, 255);
    queue_cmd(CMD_STEP, 128);
    queue_cmd(CMD_STEP, 1);
    queue_cmd(CMD_STEP, 8'hAA);
    queue_cmd(CMD_STOP, 0);
    queue_cmd(CMD_STEP, 8'h7F);
    drain_wait();

    // 3x3 grid: carve out, backtrack to empty, then idle steps
    program_grid(3, 3, 0, 0);
    queue_cmd(CMD_START, 0);
    for (n = 0; n < 9; n++) queue_cmd(CMD_STEP, 255);
    drain_wait();

    // start cell outside the grid
    program_grid(1, 64, 5, 2);
    queue_cmd(CMD_START, 0);
    queue_cmd(CMD_STEP, 0);
    drain_wait();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0, 1: begin
          sender_idle_pct <= 0;
          receiver_stall_pct <= 0;
        end
        2, 3: begin
          sender_idle_pct <= 70;
          receiver_stall_pct <= 0;
        end
        4, 5: begin
          sender_idle_pct <= 0;
          receiver_stall_pct <= 70;
        end
        default: begin
          sender_idle_pct <= 32;
          receiver_stall_pct <= 32;
        end
      endcase
      case (ph)
        0: program_grid(64, 64, 0, 0);
        1: program_grid(9, 9, 1, 1);      // shrinks the grid under a live stack
        2: program_grid(64, 64, 63, 63);
        3: program_grid(1, 1, 0, 0);
        4: program_grid(2, 64, 1, 0);
        6: program_grid(64, 1, 62, 0);
        default: program_grid($urandom_range(64, 1), $urandom_range(64, 1),
                               $urandom_range(63, 0), $urandom_range(63, 0));
      endcase
      if (ph != 1 && ph != 7) queue_cmd(CMD_START, $urandom_range(255));
      if (ph == 1) hold_requests <= hold_requests + 1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain_wait();
        r = $urandom_range(99);
        cmd = (r < 2) ? CMD_START : (r < 5) ? CMD_STOP : (r < 7) ? CMD_RSVD : CMD_STEP;
        queue_cmd(cmd, $urandom_range(255));
      end
      drain_wait();
    end

    repeat (20) @(posedge clk_i);
    $display("Ran %0d commands over 11 grid settings (%0d register writes) and four pressure modes",
             cmds_sent, cfg_writes);
    $display("Checked %0d results: %0d starts, %0d carves, %0d backtracks",
             moves_seen, starts_seen, carves_seen, backs_seen);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
